FILE: hw/rtl/vic_pkg.sv
// Shared types and constants for the voxel interior carve unit.
// No dependencies; vic_seq, vic_carve and the top level import this package.
package vic_pkg;

  // Configuration port.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // Input word modes.
  localparam logic MODE_VOXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Cycles after a size change before the derived plane and offsets are valid.
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  // History taps, read two per RAM copy.
  localparam int NUM_TAPS = 6;
  localparam int NUM_RAMS = NUM_TAPS / 2;
  localparam int TAP_YP   = 0;  // c + size_x
  localparam int TAP_XP   = 1;  // c + 1
  localparam int TAP_C    = 2;  // c
  localparam int TAP_XM   = 3;  // c - 1
  localparam int TAP_YM   = 4;  // c - size_x
  localparam int TAP_ZM   = 5;  // c - plane

  typedef struct packed {
    logic mode;
    logic voxel_in;
  } in_word_t;

  typedef struct packed {
    logic voxel_out;
    logic was_carved;
    logic last;
  } out_word_t;

  // Per-step control handed from the sequencer to the carve stage.
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
    logic voxel_n;
  } step_ctl_t;

endpackage

FILE: hw/rtl/vic_hist_ram.sv
// Voxel history ring copy: one write port, two registered read ports.
// No package dependencies; instantiated by the top level.
module vic_hist_ram #(
  parameter int DEPTH = 131073,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic          rdata_a,
  output logic          rdata_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hw/rtl/vic_seq.sv
// Sequencer: size registers, derived plane offsets, raster counters and
// history ring addressing. Depends on vic_pkg.
module vic_seq
  import vic_pkg::*;
#(
  parameter int  MAX_SIZE_X = 256,
  parameter int  MAX_SIZE_Y = 256,
  parameter int  MAX_SIZE_Z = 256,
  localparam int SXW        = $clog2(MAX_SIZE_X + 1),
  localparam int SYW        = $clog2(MAX_SIZE_Y + 1),
  localparam int SZW        = $clog2(MAX_SIZE_Z + 1),
  localparam int CXW        = $clog2(MAX_SIZE_X),
  localparam int CYW        = $clog2(MAX_SIZE_Y),
  localparam int CZW        = $clog2(MAX_SIZE_Z),
  localparam int PLANE_MAX  = MAX_SIZE_X * MAX_SIZE_Y,
  localparam int PW         = $clog2(PLANE_MAX + 1),
  localparam int DEPTH      = 2 * PLANE_MAX + 1,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 fire,
  input  in_word_t             in_word,
  output logic                 settled,
  output step_ctl_t            ctl,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic                 wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr [NUM_TAPS]
);

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw,
                                             input int unsigned max_v);
    if (raw == '0) begin
      return 1;
    end else if (32'(raw) > max_v) begin
      return max_v;
    end
    return 32'(raw);
  endfunction

  // Raw size registers and settle counter.
  logic [CFG_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [1:0]       settle_r;
  logic             cfg_hit;

  // Derived values, valid once the settle counter has run out after a size change.
  logic [SXW-1:0]   eff_x_r;
  logic [SYW-1:0]   eff_y_r;
  logic [SZW-1:0]   eff_z_r;
  logic [SXW-1:0]   xm1;
  logic [SYW-1:0]   ym1;
  logic [SZW-1:0]   zm1;
  logic [CXW-1:0]   xmax_r;
  logic [CYW-1:0]   ymax_r;
  logic [CZW-1:0]   zmax_r;
  logic [SXW+SYW-1:0] prod;
  logic [PW-1:0]    plane_r;
  logic [AW-1:0]    pl, sxa;
  logic [AW-1:0]    dly_nxt [NUM_TAPS];
  logic [AW-1:0]    dly_r   [NUM_TAPS];
  logic [AW-1:0]    ndly_r  [NUM_TAPS];

  // Stream state.
  logic [AW-1:0]  w_r, w_nxt;
  logic [CXW-1:0] in_x_r, in_x_nxt, out_x_r, out_x_nxt;
  logic [CYW-1:0] in_y_r, in_y_nxt, out_y_r, out_y_nxt;
  logic [CZW-1:0] in_z_r, in_z_nxt, out_z_r, out_z_nxt;
  logic           grid_done_r, grid_done_nxt;

  logic vox_step, step, emit, in_last, out_last, interior;

  assign cfg_hit = cfg_we && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
                              cfg_index == CFG_SIZE_Z);
  assign settled = (settle_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
      settle_r <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SIZE_X: size_x_r <= cfg_data;
          CFG_SIZE_Y: size_y_r <= cfg_data;
          CFG_SIZE_Z: size_z_r <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        settle_r <= SETTLE_CYCLES;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Three-stage derivation: clamp, then multiply, then tap offsets.
  assign xm1  = eff_x_r - SXW'(1);
  assign ym1  = eff_y_r - SYW'(1);
  assign zm1  = eff_z_r - SZW'(1);
  assign prod = {{SYW{1'b0}}, eff_x_r} * {{SXW{1'b0}}, eff_y_r};
  assign pl   = AW'(plane_r);
  assign sxa  = AW'(eff_x_r);

  always_comb begin
    dly_nxt[TAP_YP] = pl - sxa;
    dly_nxt[TAP_XP] = pl - AW'(1);
    dly_nxt[TAP_C]  = pl;
    dly_nxt[TAP_XM] = pl + AW'(1);
    dly_nxt[TAP_YM] = pl + sxa;
    dly_nxt[TAP_ZM] = pl + pl;
  end

  always_ff @(posedge clk) begin
    eff_x_r <= SXW'(clamp_size(size_x_r, MAX_SIZE_X));
    eff_y_r <= SYW'(clamp_size(size_y_r, MAX_SIZE_Y));
    eff_z_r <= SZW'(clamp_size(size_z_r, MAX_SIZE_Z));
    xmax_r  <= xm1[CXW-1:0];
    ymax_r  <= ym1[CYW-1:0];
    zmax_r  <= zm1[CZW-1:0];
    plane_r <= prod[PW-1:0];
    for (int k = 0; k < NUM_TAPS; k++) begin
      dly_r[k]  <= dly_nxt[k];
      ndly_r[k] <= AW'(DEPTH) - dly_nxt[k];
    end
  end

  // Step classification for the word on the input port.
  assign vox_step = (in_word.mode == MODE_VOXEL) && !grid_done_r;
  assign step     = vox_step || grid_done_r;
  assign emit     = vox_step ? (in_z_r != '0) : grid_done_r;
  assign in_last  = (in_x_r == xmax_r) && (in_y_r == ymax_r) && (in_z_r == zmax_r);
  assign out_last = (out_x_r == xmax_r) && (out_y_r == ymax_r) && (out_z_r == zmax_r);
  assign interior = (out_x_r != '0) && (out_x_r < xmax_r) &&
                    (out_y_r != '0) && (out_y_r < ymax_r) &&
                    (out_z_r != '0) && (out_z_r < zmax_r);

  assign ctl = '{emit: emit, interior: interior, last: out_last, voxel_n: in_word.voxel_in};

  assign wr_en   = fire && vox_step;
  assign wr_addr = w_r;
  assign wr_data = in_word.voxel_in;
  assign rd_en   = fire && emit;

  // The ring pointer tracks the index of c + plane, so each tap sits at a fixed
  // distance behind it; both wrap candidates are formed in parallel.
  always_comb begin
    logic [AW:0] diff;
    logic [AW:0] alt;
    for (int k = 0; k < NUM_TAPS; k++) begin
      diff       = {1'b0, w_r} - {1'b0, dly_r[k]};
      alt        = {1'b0, w_r} + {1'b0, ndly_r[k]};
      rd_addr[k] = diff[AW] ? alt[AW-1:0] : diff[AW-1:0];
    end
  end

  always_comb begin
    w_nxt         = w_r;
    in_x_nxt      = in_x_r;
    in_y_nxt      = in_y_r;
    in_z_nxt      = in_z_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    grid_done_nxt = grid_done_r;
    priority if (cfg_hit || (fire && emit && out_last)) begin
      w_nxt         = '0;
      in_x_nxt      = '0;
      in_y_nxt      = '0;
      in_z_nxt      = '0;
      out_x_nxt     = '0;
      out_y_nxt     = '0;
      out_z_nxt     = '0;
      grid_done_nxt = 1'b0;
    end else if (fire && step) begin
      w_nxt = (w_r == AW'(DEPTH - 1)) ? '0 : w_r + AW'(1);
      if (vox_step) begin
        if (in_last) begin
          grid_done_nxt = 1'b1;
        end
        if (in_x_r == xmax_r) begin
          in_x_nxt = '0;
          if (in_y_r == ymax_r) begin
            in_y_nxt = '0;
            in_z_nxt = (in_z_r == zmax_r) ? '0 : in_z_r + CZW'(1);
          end else begin
            in_y_nxt = in_y_r + CYW'(1);
          end
        end else begin
          in_x_nxt = in_x_r + CXW'(1);
        end
      end
      if (emit) begin
        if (out_x_r == xmax_r) begin
          out_x_nxt = '0;
          if (out_y_r == ymax_r) begin
            out_y_nxt = '0;
            out_z_nxt = out_z_r + CZW'(1);
          end else begin
            out_y_nxt = out_y_r + CYW'(1);
          end
        end else begin
          out_x_nxt = out_x_r + CXW'(1);
        end
      end
    end else begin
      w_nxt = w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= '0;
      in_x_r      <= '0;
      in_y_r      <= '0;
      in_z_r      <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_z_r     <= '0;
      grid_done_r <= 1'b0;
    end else begin
      w_r         <= w_nxt;
      in_x_r      <= in_x_nxt;
      in_y_r      <= in_y_nxt;
      in_z_r      <= in_z_nxt;
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      out_z_r     <= out_z_nxt;
      grid_done_r <= grid_done_nxt;
    end
  end

  // No word may enter while the derived offsets are still settling.
  a_fire_settled: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> settle_r == '0)
    else $error("word accepted before size offsets settled");

  // The final voxel can only be emitted once the whole grid has arrived.
  a_last_after_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && out_last) |-> grid_done_r)
    else $error("last voxel emitted before grid complete");

  // Emitting the final voxel returns the stream to its start.
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && out_last) |=> (w_r == '0 && !grid_done_r && in_z_r == '0))
    else $error("stream not restarted after last voxel");

endmodule

FILE: hw/rtl/vic_carve.sv
// Carve stage: combines the registered history taps into a result and holds
// it in the output register. Depends on vic_pkg.
module vic_carve
  import vic_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  step_ctl_t           ctl,
  input  logic [NUM_TAPS-1:0] tap,
  output logic                s1_free,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_word
);

  logic      s1_valid_r;
  step_ctl_t s1_ctl_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t res;
  logic      advance;
  logic      orig, nbrs, carved;

  assign advance = !out_valid_r || out_ready;
  assign s1_free = !s1_valid_r || advance;

  // The +z neighbour is the word that arrived with this step, not a ring read.
  assign orig   = tap[TAP_C];
  assign nbrs   = tap[TAP_YP] & tap[TAP_XP] & tap[TAP_XM] & tap[TAP_YM] &
                  tap[TAP_ZM] & s1_ctl_r.voxel_n;
  assign carved = orig & s1_ctl_r.interior & nbrs;
  assign res    = '{voxel_out: orig & ~carved, was_carved: carved, last: s1_ctl_r.last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && ctl.emit) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.emit) begin
      s1_ctl_r <= ctl;
    end
    if (advance && s1_valid_r) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A new step never lands on a stage word that has not moved on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctl.emit) |-> (!s1_valid_r || advance))
    else $error("stage word overwritten");

  // A stalled stage word is kept.
  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("stalled stage word lost");

  // The final voxel is a corner of the grid and is never carved.
  a_last_not_carved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.last) |-> !out_word_r.was_carved)
    else $error("last voxel reported as carved");

endmodule

FILE: hw/rtl/voxel_interior_carve_unit.sv
// Top level of the voxel interior carve unit: sequencer, three history RAM
// copies and the carve stage. Depends on vic_pkg, vic_seq, vic_hist_ram, vic_carve.
//
// Usage. Occupancy words enter on the in_ channel in raster order, x fastest,
// then y, then z. A voxel word (mode 0) is stored in the plane history; each
// voxel is emitted on the out_ channel once the word one plane later has
// arrived, cleared when it is interior and all six face neighbours are set.
// After the grid, flush words (mode 1, or any word) push out the last plane;
// the result for the final voxel carries last, and the stream then restarts.
// Flush words sent before the grid is complete are dropped without a result.
// The cfg_ port writes size_x, size_y and size_z (zero reads as one, values
// above the maximum clamp); any write to a size register restarts the stream.
// Throughput is one word per cycle while in_ready is high. A result passes the
// registered history RAM reads and then the output register after the word that
// causes it. Six taps are read per emitted result, two from each RAM copy.
// After reset and after each size write, in_ready stays low while the plane
// size and tap offsets are recomputed; there is no clearing pass, since only
// history written in the current grid ever affects a result.
// When the receiver stalls, the output register and one stage word hold, and
// in_ready drops once both are full.
module voxel_interior_carve_unit
  import vic_pkg::*;
#(
  parameter int  MAX_SIZE_X = 256,
  parameter int  MAX_SIZE_Y = 256,
  parameter int  MAX_SIZE_Z = 256,
  localparam int DEPTH      = 2 * MAX_SIZE_X * MAX_SIZE_Y + 1,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word
);

  logic                settled;
  logic                s1_free;
  logic                fire;
  step_ctl_t           ctl;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr [NUM_TAPS];
  wire  [NUM_TAPS-1:0] tap;

  // A word is taken whenever the offsets are valid and the stage word can move.
  assign in_ready = settled && s1_free;
  assign fire     = in_valid && in_ready;

  vic_seq #(
    .MAX_SIZE_X(MAX_SIZE_X),
    .MAX_SIZE_Y(MAX_SIZE_Y),
    .MAX_SIZE_Z(MAX_SIZE_Z)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (fire),
    .in_word  (in_word),
    .settled  (settled),
    .ctl      (ctl),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  // Identical copies of the history ring, each serving two of the six taps.
  for (genvar g = 0; g < NUM_RAMS; g++) begin : g_ram
    vic_hist_ram #(
      .DEPTH(DEPTH)
    ) u_ram (
      .clk    (clk),
      .we     (wr_en),
      .waddr  (wr_addr),
      .wdata  (wr_data),
      .re     (rd_en),
      .raddr_a(rd_addr[2*g]),
      .raddr_b(rd_addr[2*g+1]),
      .rdata_a(tap[2*g]),
      .rdata_b(tap[2*g+1])
    );
  end

  vic_carve u_carve (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .ctl      (ctl),
    .tap      (tap),
    .s1_free  (s1_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule
